### rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert that a property holds at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assert a same-cycle (overlapping) implication
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/dct2d_pkg.sv
// ----------------------------------------------------------------------------
// dct2d_pkg
// constants, coefficient table and state type for the 2-d dct core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dct2d_pkg;

  localparam int unsigned BlockSize    = 8;
  localparam int unsigned CoefFracBits = 14;
  localparam int unsigned InterFrac    = 4;
  localparam int unsigned InterWidth   = 24;
  localparam int unsigned SampleWidth  = 16;
  localparam int unsigned CoefWidth    = 16;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MAC,
    ST_ROUND,
    ST_WRITE,
    ST_EMIT
  } dct_state_e;

  // 8-point orthonormal dct-ii matrix, q1.14, c[k][n]
  typedef logic signed [CoefWidth-1:0] coef_row_t [0:7];
  typedef coef_row_t coef_tab_t [0:7];

  localparam coef_tab_t CoefTab = '{
    '{16'sd5793,  16'sd5793,  16'sd5793,  16'sd5793,
      16'sd5793,  16'sd5793,  16'sd5793,  16'sd5793},
    '{16'sd8035,  16'sd6811,  16'sd4551,  16'sd1598,
      -16'sd1598, -16'sd4551, -16'sd6811, -16'sd8035},
    '{16'sd7568,  16'sd3135,  -16'sd3135, -16'sd7568,
      -16'sd7568, -16'sd3135, 16'sd3135,  16'sd7568},
    '{16'sd6811,  -16'sd1598, -16'sd8035, -16'sd4551,
      16'sd4551,  16'sd8035,  16'sd1598,  -16'sd6811},
    '{16'sd5793,  -16'sd5793, -16'sd5793, 16'sd5793,
      16'sd5793,  -16'sd5793, -16'sd5793, 16'sd5793},
    '{16'sd4551,  -16'sd8035, 16'sd1598,  16'sd6811,
      -16'sd6811, -16'sd1598, 16'sd8035,  -16'sd4551},
    '{16'sd3135,  -16'sd7568, 16'sd7568,  -16'sd3135,
      -16'sd3135, 16'sd7568,  -16'sd7568, 16'sd3135},
    '{16'sd1598,  -16'sd4551, 16'sd6811,  -16'sd8035,
      16'sd8035,  -16'sd6811, 16'sd4551,  -16'sd1598}
  };

  function automatic logic signed [CoefWidth-1:0] coef_at(input logic [2:0] k,
                                                           input logic [2:0] n);
    coef_at = CoefTab[k][n];
  endfunction

endpackage

### rtl/dct_2d_forward_inverse_core.sv
// ----------------------------------------------------------------------------
// dct_2d_forward_inverse_core
// 8x8 orthonormal 2-d dct-ii / dct-iii, row-column, bit-serial multiply
// ----------------------------------------------------------------------------
// usage: samples enter in raster order on sample_value_i with sample_valid_i /
// sample_stall_o; 64 items make one block. inverse_mode_i with
// inverse_mode_we_i picks dct-ii (0) or dct-iii (1); the mode held when a
// block's last sample is taken applies to it. the core then runs two passes
// of 64 dot products each, 8 products per value, each product built
// bit-serially over 16 multiplier bits plus fetch, load and add steps in one
// shared shift-add multiplier. results leave in raster order on
// result_value_o / block_last_o with result_valid_o / result_stall_i.
// after the last sample both passes finish before the first result, then one
// result per cycle while not stalled; the single shared multiplier sets the
// rate of whole blocks.
// the input is stalled while a block is transformed or emitted.
// reset clears the control state; stores need no clearing.
// a stalled result holds its value until taken.
`timescale 1ns / 1ps

module dct_2d_forward_inverse_core (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     inverse_mode_we_i,
  input  logic                                     inverse_mode_i,
  input  logic                                     sample_valid_i,
  output logic                                     sample_stall_o,
  input  logic signed [dct2d_pkg::SampleWidth-1:0] sample_value_i,
  output logic                                     result_valid_o,
  input  logic                                     result_stall_i,
  output logic signed [dct2d_pkg::SampleWidth-1:0] result_value_o,
  output logic                                     block_last_o
);

  localparam int unsigned CW  = dct2d_pkg::CoefWidth;
  localparam int unsigned IW  = dct2d_pkg::InterWidth;
  localparam int unsigned PW  = IW + CW;
  localparam int unsigned AW  = PW + 4;
  localparam int unsigned SampleWidthL = dct2d_pkg::SampleWidth;

  dct2d_pkg::dct_state_e state_q, state_d;

  logic                 mode_q;
  logic                 run_mode_q, run_mode_d;
  logic [5:0]           cnt_q, cnt_d;
  logic                 pass_q, pass_d;
  logic [2:0]           tap_q, tap_d;
  logic [4:0]           bit_q, bit_d;
  logic [5:0]           ecnt_q, ecnt_d;

  logic signed [IW-1:0] in_mem [0:63];
  logic signed [IW-1:0] tr_mem [0:63];
  logic signed [IW-1:0] out_mem [0:63];

  logic signed [IW-1:0] rd_q;
  logic signed [AW-1:0] acc_q, acc_d;
  logic signed [PW-1:0] prod_q, prod_d;
  logic [CW-1:0]        mpl_q, mpl_d;
  logic signed [IW-1:0] mcand_q;

  logic [2:0]           ra, rb, tk, tn;
  logic [5:0]           rd_addr, wr_addr;
  logic                 in_acc, out_acc;
  logic signed [CW-1:0] cval;
  logic [5:0]           sh;
  logic signed [AW-1:0] rnd_v;
  logic signed [IW-1:0] sat_v;
  logic                 start_mul, mac_step, do_write;
  logic [4:0]           bidx;
  logic signed [SampleWidthL-1:0] emit_v;

  assign in_acc  = sample_valid_i && !sample_stall_o;
  assign out_acc = result_valid_o && !result_stall_i;
  assign sample_stall_o = (state_q != dct2d_pkg::ST_LOAD);

  // output index cnt = a*8+b, tap = c
  assign ra = cnt_q[5:3];
  assign rb = cnt_q[2:0];
  always_comb begin
    if (pass_q == 1'b0) begin
      if (!run_mode_q) begin
        rd_addr = {ra, tap_q};
        tk = rb; tn = tap_q;
        wr_addr = {ra, rb};
      end else begin
        rd_addr = {tap_q, ra};
        tk = tap_q; tn = rb;
        wr_addr = {rb, ra};
      end
    end else begin
      if (!run_mode_q) begin
        rd_addr = {tap_q, rb};
        tk = ra; tn = tap_q;
      end else begin
        rd_addr = {ra, tap_q};
        tk = tap_q; tn = rb;
      end
      wr_addr = {ra, rb};
    end
  end

  assign cval = dct2d_pkg::coef_at(tk, tn);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_mem[cnt_q] <= IW'(sample_value_i);
    end
    if (do_write && !pass_q) begin
      tr_mem[wr_addr] <= sat_v;
    end
    if (do_write && pass_q) begin
      out_mem[wr_addr] <= sat_v;
    end
    if (pass_q) begin
      rd_q <= tr_mem[rd_addr];
    end else begin
      rd_q <= in_mem[rd_addr];
    end
    emit_v <= SampleWidthL'(out_mem[ecnt_d]);
    if (start_mul) begin
      mcand_q <= rd_q;
    end
    prod_q <= prod_d;
    mpl_q  <= mpl_d;
  end

  // round to nearest, ties away, then saturate
  always_comb begin
    logic signed [AW-1:0] mag, hi, lo, lim;
    logic                 neg;
    sh  = pass_q ? 6'(dct2d_pkg::CoefFracBits + dct2d_pkg::InterFrac)
                 : 6'(dct2d_pkg::CoefFracBits - dct2d_pkg::InterFrac);
    neg = acc_q[AW-1];
    mag = neg ? -acc_q : acc_q;
    mag = (mag + (AW'(1) <<< (sh - 6'd1))) >>> sh;
    rnd_v = neg ? -mag : mag;
    lim = pass_q ? AW'(16) : AW'(IW);
    hi = (AW'(1) <<< (lim - AW'(1))) - AW'(1);
    lo = -hi - AW'(1);
    if (rnd_v > hi) begin
      sat_v = IW'(hi);
    end else if (rnd_v < lo) begin
      sat_v = IW'(lo);
    end else begin
      sat_v = IW'(rnd_v);
    end
  end

  // multiplier bit index, steps 2..17 carry bits 0..15
  assign bidx = bit_q - 5'd2;

  // bit-serial multiply: one multiplier bit a cycle, lsb first
  always_comb begin
    prod_d = prod_q;
    mpl_d  = mpl_q;
    if (start_mul) begin
      prod_d = '0;
      mpl_d  = cval;
    end else if (mac_step) begin
      if (bidx == 5'(CW - 1)) begin
        if (mpl_q[0]) prod_d = prod_q - (PW'(mcand_q) <<< bidx);
      end else begin
        if (mpl_q[0]) prod_d = prod_q + (PW'(mcand_q) <<< bidx);
      end
      mpl_d = mpl_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dct2d_pkg::ST_LOAD;
      mode_q     <= 1'b0;
      run_mode_q <= 1'b0;
      cnt_q      <= '0;
      pass_q     <= 1'b0;
      tap_q      <= '0;
      bit_q      <= '0;
      ecnt_q     <= '0;
      acc_q      <= '0;
    end else begin
      state_q    <= state_d;
      if (inverse_mode_we_i) mode_q <= inverse_mode_i;
      run_mode_q <= run_mode_d;
      cnt_q      <= cnt_d;
      pass_q     <= pass_d;
      tap_q      <= tap_d;
      bit_q      <= bit_d;
      ecnt_q     <= ecnt_d;
      acc_q      <= acc_d;
    end
  end

  // bit_q: 0 = fetch wait, 1 = load operand, 2..17 = multiply bits, 18 = add
  always_comb begin
    state_d    = state_q;
    run_mode_d = run_mode_q;
    cnt_d      = cnt_q;
    pass_d     = pass_q;
    tap_d      = tap_q;
    bit_d      = bit_q;
    ecnt_d     = ecnt_q;
    acc_d      = acc_q;
    start_mul  = 1'b0;
    mac_step   = 1'b0;
    do_write   = 1'b0;
    case (state_q)
      dct2d_pkg::ST_LOAD: begin
        if (in_acc) begin
          cnt_d = cnt_q + 6'd1;
          if (cnt_q == 6'd63) begin
            state_d    = dct2d_pkg::ST_MAC;
            run_mode_d = mode_q;
            cnt_d      = '0;
            pass_d     = 1'b0;
            tap_d      = '0;
            bit_d      = '0;
            acc_d      = '0;
          end
        end
      end
      dct2d_pkg::ST_MAC: begin
        bit_d = bit_q + 5'd1;
        if (bit_q == 5'd1) begin
          start_mul = 1'b1;
        end else if (bit_q >= 5'd2 && bit_q <= 5'd17) begin
          mac_step = 1'b1;
        end else if (bit_q == 5'd18) begin
          acc_d = acc_q + AW'(prod_q);
          bit_d = '0;
          tap_d = tap_q + 3'd1;
          if (tap_q == 3'd7) state_d = dct2d_pkg::ST_ROUND;
        end
      end
      dct2d_pkg::ST_ROUND: begin
        state_d = dct2d_pkg::ST_WRITE;
      end
      dct2d_pkg::ST_WRITE: begin
        do_write = 1'b1;
        acc_d    = '0;
        tap_d    = '0;
        bit_d    = '0;
        cnt_d    = cnt_q + 6'd1;
        state_d  = dct2d_pkg::ST_MAC;
        if (cnt_q == 6'd63) begin
          if (!pass_q) begin
            pass_d = 1'b1;
          end else begin
            state_d = dct2d_pkg::ST_EMIT;
            ecnt_d  = '0;
          end
        end
      end
      dct2d_pkg::ST_EMIT: begin
        if (out_acc) begin
          ecnt_d = ecnt_q + 6'd1;
          if (ecnt_q == 6'd63) begin
            state_d = dct2d_pkg::ST_LOAD;
            pass_d  = 1'b0;
          end
        end
      end
      default: begin
        state_d = dct2d_pkg::ST_LOAD;
      end
    endcase
  end

  logic emit_v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_v_q <= 1'b0;
    end else begin
      emit_v_q <= (state_d == dct2d_pkg::ST_EMIT);
    end
  end

  assign result_valid_o = emit_v_q && (state_q == dct2d_pkg::ST_EMIT);
  assign result_value_o = emit_v;
  assign block_last_o   = (ecnt_q == 6'd63);

endmodule

### rtl/dct2d_checker.sv
// ----------------------------------------------------------------------------
// dct2d_checker
// port-level checks for the 2-d dct core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dct2d_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic sample_stall_o,
  input logic result_valid_o,
  input logic result_stall_i,
  input logic block_last_o,
  input logic signed [15:0] result_value_o
);

  `ASSERT_IMPL(a_no_overlap, clk_i, rst_ni, result_valid_o, sample_stall_o, "input open while emitting")
  `ASSERT_CLK(a_hold_val, clk_i, rst_ni, (result_valid_o && result_stall_i) |=> $stable(result_value_o), "stalled result changed")
  `ASSERT_CLK(a_last_ends, clk_i, rst_ni, (result_valid_o && !result_stall_i && block_last_o) |=> !result_valid_o, "output after block end")

endmodule

bind dct_2d_forward_inverse_core dct2d_checker u_dct2d_checker (.*);

### bench/dct_2d_forward_inverse_core_tb.sv
// ----------------------------------------------------------------------------
// dct_2d_forward_inverse_core_tb
// block-level check of the 8x8 forward / inverse 2-d dct core
// ----------------------------------------------------------------------------
// builds its own fixed-point coefficient table and row-column transform,
// feeds directed and random blocks in both modes, including a mode change
// in the middle of a block, and compares every result item in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dct_2d_forward_inverse_core_tb;

  localparam int N          = int'(dct2d_pkg::BlockSize);
  localparam int Total      = N * N;
  localparam int Frac       = int'(dct2d_pkg::CoefFracBits);
  localparam int Inter      = int'(dct2d_pkg::InterFrac);
  localparam int InterW     = int'(dct2d_pkg::InterWidth);
  localparam int IdleLimit  = 80000;
  localparam int SettleWait = 40;
  localparam longint unsigned PiQ30  = 64'd3373259426;
  localparam longint OneQ30 = 64'sd1073741824;

  typedef enum logic [1:0] {
    STIM_SAMPLE,
    STIM_MODE,
    STIM_DRAIN
  } stim_kind_e;

  typedef struct packed {
    stim_kind_e         kind;
    logic signed [15:0] value;
  } stim_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic               last;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic inverse_mode_we_i = 1'b0;
  logic inverse_mode_i = 1'b0;
  logic sample_valid_i = 1'b0;
  logic sample_stall_o;
  logic signed [15:0] sample_value_i = '0;
  logic result_valid_o;
  logic result_stall_i = 1'b0;
  logic signed [15:0] result_value_o;
  logic block_last_o;

  dct_2d_forward_inverse_core i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .inverse_mode_we_i (inverse_mode_we_i),
    .inverse_mode_i    (inverse_mode_i),
    .sample_valid_i    (sample_valid_i),
    .sample_stall_o    (sample_stall_o),
    .sample_value_i    (sample_value_i),
    .result_valid_o    (result_valid_o),
    .result_stall_i    (result_stall_i),
    .result_value_o    (result_value_o),
    .block_last_o      (block_last_o)
  );

  longint coef_q[N][N];
  longint block_buf[Total];
  longint mid_buf[Total];
  int     fill_count = 0;
  logic   mode_shadow = 1'b0;
  stim_t  stim_q[$];
  pixel_t pixel_q[$];
  int     errors = 0;
  int     idle_cycles = 0;
  int     gap_left = 0;
  int     stall_left = 0;
  int     settle = 0;
  logic   sample_taken = 1'b0;
  bit     burst_mode = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint rnd_shift(longint v, int s);
    longint unsigned mag;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint clamp_bits(longint v, int bits);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint cos_first(longint unsigned q);
    longint unsigned t;
    longint unsigned x2;
    longint unsigned term;
    longint acc;
    t = (PiQ30 * q + N) / (2 * N);
    x2 = (t * t) >> 30;
    term = OneQ30;
    acc = OneQ30;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * x2) >> 30) / ((2 * k - 1) * (2 * k));
      if (k % 2) acc -= longint'(term);
      else acc += longint'(term);
    end
    return acc;
  endfunction

  function automatic longint cos_full(longint unsigned m);
    m = m % (4 * N);
    if (m <= N) return cos_first(m);
    if (m <= 2 * N) return -cos_first(2 * N - m);
    if (m <= 3 * N) return -cos_first(m - 2 * N);
    return cos_first(4 * N - m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic build_coefs();
    longint alpha;
    for (int k = 0; k < N; k++) begin
      alpha = longint'(int_sqrt(((k == 0 ? 64'd1 : 64'd2) << 60) / N));
      for (int n = 0; n < N; n++)
        coef_q[k][n] = rnd_shift(cos_full((2 * n + 1) * k) * alpha, 60 - Frac);
    end
  endtask

  // two passes over the loaded block, results queued in raster order
  task automatic transform_block();
    longint acc;
    pixel_t px;
    for (int a = 0; a < N; a++)
      for (int b = 0; b < N; b++) begin
        acc = 0;
        for (int c = 0; c < N; c++)
          if (!mode_shadow) acc += block_buf[a * N + c] * coef_q[b][c];
          else acc += block_buf[c * N + a] * coef_q[c][b];
        acc = clamp_bits(rnd_shift(acc, Frac - Inter), InterW);
        if (!mode_shadow) mid_buf[a * N + b] = acc;
        else mid_buf[b * N + a] = acc;
      end
    for (int i = 0; i < N; i++)
      for (int j = 0; j < N; j++) begin
        acc = 0;
        for (int c = 0; c < N; c++)
          if (!mode_shadow) acc += mid_buf[c * N + j] * coef_q[i][c];
          else acc += mid_buf[i * N + c] * coef_q[c][j];
        px.value = 16'(clamp_bits(rnd_shift(acc, Frac + Inter), 16));
        px.last = (i * N + j == Total - 1);
        pixel_q.push_back(px);
      end
  endtask

  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // sample driver
  always @(negedge clk_i) begin
    logic nv;
    logic we;
    logic [15:0] val;
    nv = sample_valid_i && !sample_taken;
    we = 1'b0;
    val = sample_value_i;
    if (pixel_q.size() == 0) settle = settle + 1;
    else settle = 0;
    if (rst_ni && !nv) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
      end else if (stim_q.size() > 0) begin
        case (stim_q[0].kind)
          STIM_SAMPLE: begin
            nv = 1'b1;
            val = stim_q[0].value;
            void'(stim_q.pop_front());
            gap_left = pick_gap();
          end
          STIM_MODE: begin
            if (pixel_q.size() == 0 && settle >= SettleWait) begin
              we = 1'b1;
              inverse_mode_i <= stim_q[0].value[0];
              void'(stim_q.pop_front());
            end
          end
          default: begin
            if (pixel_q.size() == 0) begin
              void'(stim_q.pop_front());
              burst_mode = $urandom_range(0, 1);
            end
          end
        endcase
      end
    end
    sample_valid_i <= nv;
    sample_value_i <= val;
    inverse_mode_we_i <= we;
  end

  // result stall driver
  always @(negedge clk_i) begin
    int r;
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else if (!burst_mode) begin
      r = $urandom_range(0, 99);
      if (r < 20) stall_left = $urandom_range(1, 3);
      else if (r < 23) stall_left = $urandom_range(10, 50);
    end
    result_stall_i <= (stall_left > 0);
  end

  // monitor and prediction
  always @(posedge clk_i) begin
    pixel_t want;
    logic took;
    took = rst_ni && sample_valid_i && !sample_stall_o;
    sample_taken <= took;
    if (rst_ni && result_valid_o && !result_stall_i) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected item value=%0d last=%0b", $realtime, result_value_o,
                 block_last_o);
        errors++;
      end else begin
        want = pixel_q.pop_front();
        if (result_value_o !== want.value) begin
          $display("%0t: value mismatch expected=%0d actual=%0d", $realtime, want.value,
                   result_value_o);
          errors++;
        end
        if (block_last_o !== want.last) begin
          $display("%0t: last mismatch expected=%0b actual=%0b", $realtime, want.last,
                   block_last_o);
          errors++;
        end
      end
    end
    if (rst_ni && inverse_mode_we_i) mode_shadow = inverse_mode_i;
    if (took) begin
      block_buf[fill_count] = sample_value_i;
      fill_count++;
      if (fill_count == Total) begin
        fill_count = 0;
        transform_block();
      end
    end
    if (took || inverse_mode_we_i || (result_valid_o && !result_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void add_sample(int v);
    stim_t s;
    s.kind = STIM_SAMPLE;
    s.value = 16'(v);
    stim_q.push_back(s);
  endfunction

  function automatic void add_ctrl(stim_kind_e k, int v);
    stim_t s;
    s.kind = k;
    s.value = 16'(v);
    stim_q.push_back(s);
  endfunction

  function automatic int rand_value(int flavor);
    case (flavor)
      0: return $urandom_range(0, 65535) - 32768;
      1: return $urandom_range(0, 511) - 256;
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) - 4096 : 0;
    endcase
  endfunction

  initial begin
    int extremes[10];
    extremes = '{32767, -32768, 0, 1, -1, 16384, -16384, 21845, -21846, 255};
    build_coefs();

    // forward, field extremes and a saturating dc
    for (int i = 0; i < 25; i++) add_sample(extremes[i % 10]);
    for (int i = 25; i < Total; i++) add_sample(32767);
    add_ctrl(STIM_MODE, 1);
    // inverse, large values then random, mode flips during loading
    for (int i = 0; i < Total; i++) begin
      if (i == 20) add_ctrl(STIM_MODE, 0);
      if (i == 50) begin
        add_ctrl(STIM_DRAIN, 0);
        add_ctrl(STIM_MODE, 1);
      end
      if (i < 32) add_sample(i % 2 ? -32768 : 32767);
      else add_sample(rand_value(0));
    end
    add_ctrl(STIM_DRAIN, 0);
    add_ctrl(STIM_MODE, 0);
    // trailing partial block, no results expected
    for (int i = 0; i < 22; i++) add_sample(rand_value(i % 3));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() > 0 || sample_valid_i || pixel_q.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/dct2d_pkg.sv
rtl/dct_2d_forward_inverse_core.sv
rtl/dct2d_checker.sv
bench/dct_2d_forward_inverse_core_tb.sv
